### sv/gear_ratio_estimator_assert.svh
// Assertion macros for the gear ratio estimator.
`ifndef GEAR_RATIO_ESTIMATOR_ASSERT_SVH
`define GEAR_RATIO_ESTIMATOR_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define GRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define GRE_NEVER(label, cond, msg) \
  `GRE_ASSERT(label, !(cond), msg)

`endif

### sv/gre_pkg.sv
// Types and constants of the gear ratio estimator.
package gre_pkg;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_FILT = 6'b000100,
    ST_CHK  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_SCAN = 6'b100000
  } state_e;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_CALIB  = 2'd1;
  localparam logic [1:0] FUNC_LOAD   = 2'd2;

  localparam logic [1:0] CFG_GAIN    = 2'd0;
  localparam logic [1:0] CFG_MIN_RPM = 2'd1;

  localparam logic [15:0] GAIN_RESET    = 16'd19661;
  localparam logic [13:0] MIN_RPM_RESET = 14'd300;

  localparam logic [23:0] SPEED_FLOOR       = 24'd2560;
  localparam logic [31:0] GEAR_RATIO_FLOOR  = 32'd9;
  localparam logic [31:0] CALIB_RATIO_FLOOR = 32'd164;
  localparam logic [16:0] RATIO_SCALE       = 17'd100;

  localparam int unsigned DIV_STEPS = 48;

endpackage

### sv/gear_ratio_estimator.sv
// Gear ratio estimator: filter, shared divider and sequential gear scan.
// Start an item with start while busy is low. The result appears for one
// cycle with done_o and cannot be held off. A sample runs filter, ratio
// check, divider and gear scan, skipping the divider when the smoothed values
// give no valid ratio; a calibrate item runs divider and scan (only the scan
// when ignored), a load only the scan. The 48-step restoring divider is shared
// by ratio and average; the scan takes one coefficient a cycle.
// Configuration writes are always taken.
module gear_ratio_estimator #(
  parameter int GEAR_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [13:0] rpm_i,
  input  logic [15:0] speed_i,
  input  logic [3:0]  gear_number_i,
  input  logic [3:0]  coeff_index_i,
  input  logic [31:0] coeff_value_i,
  output logic        done_o,
  output logic [3:0]  gear_o,
  output logic [31:0] ratio_o,
  output logic [21:0] smooth_rpm_o,
  output logic [23:0] smooth_speed_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int GW = (GEAR_COUNT > 1) ? $clog2(GEAR_COUNT) : 1;
  localparam int CW = $clog2(GEAR_COUNT + 1);

  gre_pkg::state_e state_q, state_d;

  logic [15:0] gain_q;
  logic [13:0] min_rpm_q;
  logic [21:0] frpm_q;
  logic [23:0] fspd_q;
  logic [31:0] ratio_q;
  logic [31:0] coef_q [GEAR_COUNT];
  logic [47:0] sum_q  [GEAR_COUNT];
  logic [15:0] cnt_q  [GEAR_COUNT];

  logic [1:0]  func_q;
  logic [13:0] rpm_q;
  logic [15:0] speed_q;
  logic [3:0]  gnum_q;
  logic [3:0]  cidx_q;
  logic [31:0] cval_q;

  logic [1:0]         phase_q;
  logic signed [41:0] prod_q;
  logic [47:0]        num_q;
  logic [23:0]        rem_q;
  logic [23:0]        den_q;
  logic [5:0]         div_cnt_q;

  logic [CW-1:0] scan_cnt_q;
  logic          found_q;
  logic [31:0]   best_diff_q;
  logic [CW-1:0] best_q;

  logic          done_q;
  logic          status_q;
  logic [3:0]    gear_q;

  // Shared multiplier operands
  logic signed [24:0] d_rpm, d_spd, mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] prod_d;

  always_comb begin
    d_rpm = $signed({3'b0, rpm_q, 8'b0}) - $signed({3'b0, frpm_q});
    d_spd = $signed({1'b0, speed_q, 8'b0}) - $signed({1'b0, fspd_q});
    unique case (phase_q)
      2'd0:    begin mul_a = d_rpm; mul_b = $signed({1'b0, gain_q}); end
      2'd1:    begin mul_a = d_spd; mul_b = $signed({1'b0, gain_q}); end
      default: begin
        mul_a = $signed({3'b0, frpm_q});
        mul_b = $signed(gre_pkg::RATIO_SCALE);
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Round half up, add to the filter state, clamp
  logic signed [41:0] rnd;
  logic signed [26:0] step;
  logic signed [26:0] r_rpm, r_spd;
  logic [21:0]        frpm_new;
  logic [23:0]        fspd_new;

  always_comb begin
    rnd   = (prod_q + 42'sd32768) >>> 16;
    step  = rnd[26:0];
    r_rpm = $signed({5'b0, frpm_q}) + step;
    r_spd = $signed({3'b0, fspd_q}) + step;
    if (r_rpm[26])                  frpm_new = '0;
    else if (r_rpm[25:22] != 4'd0)  frpm_new = '1;
    else                            frpm_new = r_rpm[21:0];
    if (r_spd[26])                  fspd_new = '0;
    else if (r_spd[25:24] != 2'd0)  fspd_new = '1;
    else                            fspd_new = r_spd[23:0];
  end

  // Restoring divider step
  logic [24:0] rem_sh;
  logic [25:0] rem_diff;
  logic        q_bit;
  logic [31:0] quot_sat;

  always_comb begin
    rem_sh   = {rem_q, num_q[47]};
    rem_diff = {1'b0, rem_sh} - {2'b0, den_q};
    q_bit    = !rem_diff[25];
    quot_sat = (num_q[46:31] != 16'd0) ? 32'hFFFF_FFFF : {num_q[30:0], q_bit};
  end

  // Calibrate and load checks
  logic [GW-1:0] cal_k;
  logic          cal_ok, load_ok;
  logic [48:0]   sum_add;
  logic [47:0]   sum_new;
  logic [15:0]   cnt_new;

  always_comb begin
    cal_k   = GW'(gnum_q - 4'd1);
    cal_ok  = (gnum_q != 4'd0) && ({1'b0, gnum_q} <= 5'(GEAR_COUNT))
              && (ratio_q >= gre_pkg::CALIB_RATIO_FLOOR);
    load_ok = {1'b0, cidx_q} < 5'(GEAR_COUNT);
    sum_add = {1'b0, sum_q[cal_k]} + {17'b0, ratio_q};
    sum_new = sum_add[48] ? '1 : sum_add[47:0];
    cnt_new = (cnt_q[cal_k] == 16'hFFFF) ? cnt_q[cal_k] : cnt_q[cal_k] + 16'd1;
  end

  // Gear scan compare
  logic [31:0]   scan_c, scan_diff;
  logic          scan_take;
  logic [CW-1:0] best_nx;

  always_comb begin
    scan_c    = coef_q[scan_cnt_q[GW-1:0]];
    scan_diff = (ratio_q > scan_c) ? ratio_q - scan_c : scan_c - ratio_q;
    scan_take = (scan_c != 32'd0) && (!found_q || scan_diff < best_diff_q);
    best_nx   = scan_take ? scan_cnt_q + CW'(1) : best_q;
  end

  logic valid_ratio;
  assign valid_ratio = (fspd_q > gre_pkg::SPEED_FLOOR) && (frpm_q > {min_rpm_q, 8'b0});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gre_pkg::ST_IDLE: if (start) state_d = gre_pkg::ST_EXEC;
      gre_pkg::ST_EXEC: begin
        unique case (func_q)
          gre_pkg::FUNC_SAMPLE: state_d = gre_pkg::ST_FILT;
          gre_pkg::FUNC_CALIB:  state_d = cal_ok ? gre_pkg::ST_DIV : gre_pkg::ST_SCAN;
          default:              state_d = gre_pkg::ST_SCAN;
        endcase
      end
      gre_pkg::ST_FILT: if (phase_q == 2'd2) state_d = gre_pkg::ST_CHK;
      gre_pkg::ST_CHK:  state_d = valid_ratio ? gre_pkg::ST_DIV : gre_pkg::ST_SCAN;
      gre_pkg::ST_DIV:
        if (div_cnt_q == 6'(gre_pkg::DIV_STEPS - 1)) state_d = gre_pkg::ST_SCAN;
      gre_pkg::ST_SCAN:
        if (scan_cnt_q == CW'(GEAR_COUNT - 1)) state_d = gre_pkg::ST_IDLE;
      default: state_d = gre_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gre_pkg::ST_IDLE;
      gain_q      <= gre_pkg::GAIN_RESET;
      min_rpm_q   <= gre_pkg::MIN_RPM_RESET;
      frpm_q      <= '0;
      fspd_q      <= '0;
      ratio_q     <= '0;
      for (int i = 0; i < GEAR_COUNT; i++) begin
        coef_q[i] <= '0;
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
      end
      phase_q     <= '0;
      div_cnt_q   <= '0;
      scan_cnt_q  <= '0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
      status_q    <= 1'b0;
      gear_q      <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == gre_pkg::CFG_GAIN)    gain_q    <= cfg_data_i;
        if (cfg_index_i == gre_pkg::CFG_MIN_RPM) min_rpm_q <= cfg_data_i[13:0];
      end
      unique case (state_q)
        gre_pkg::ST_EXEC: begin
          phase_q    <= '0;
          div_cnt_q  <= '0;
          scan_cnt_q <= '0;
          found_q    <= 1'b0;
          status_q   <= 1'b0;
          unique case (func_q)
            gre_pkg::FUNC_SAMPLE: ;
            gre_pkg::FUNC_CALIB: begin
              if (cal_ok) begin
                sum_q[cal_k] <= sum_new;
                cnt_q[cal_k] <= cnt_new;
              end else begin
                status_q <= 1'b1;
              end
            end
            gre_pkg::FUNC_LOAD: begin
              if (load_ok) coef_q[GW'(cidx_q)] <= cval_q;
              else         status_q <= 1'b1;
            end
            default: status_q <= 1'b1;
          endcase
        end
        gre_pkg::ST_FILT: begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd1) frpm_q <= frpm_new;
          if (phase_q == 2'd2) fspd_q <= fspd_new;
        end
        gre_pkg::ST_CHK: if (!valid_ratio) ratio_q <= '0;
        gre_pkg::ST_DIV: begin
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == 6'(gre_pkg::DIV_STEPS - 1)) begin
            // hold the divider result in the target
            if (func_q == gre_pkg::FUNC_SAMPLE) ratio_q        <= quot_sat;
            else                                coef_q[cal_k] <= quot_sat;
          end
        end
        gre_pkg::ST_SCAN: begin
          scan_cnt_q <= scan_cnt_q + CW'(1);
          if (scan_take) found_q <= 1'b1;
          if (scan_cnt_q == CW'(GEAR_COUNT - 1)) begin
            done_q <= 1'b1;
            gear_q <= (ratio_q < gre_pkg::GEAR_RATIO_FLOOR) ? 4'd0 : 4'(best_nx);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == gre_pkg::ST_IDLE && start) begin
      func_q  <= func_i;
      rpm_q   <= rpm_i;
      speed_q <= speed_i;
      gnum_q  <= gear_number_i;
      cidx_q  <= coeff_index_i;
      cval_q  <= coeff_value_i;
    end
    prod_q <= prod_d;
    if (state_q == gre_pkg::ST_EXEC) begin
      best_q <= '0;
      num_q  <= sum_new;
      rem_q  <= '0;
      den_q  <= {8'b0, cnt_new};
    end else if (state_q == gre_pkg::ST_CHK) begin
      num_q <= {5'b0, prod_q[28:0], 14'b0};
      rem_q <= '0;
      den_q <= fspd_q;
    end else if (state_q == gre_pkg::ST_DIV) begin
      num_q <= {num_q[46:0], q_bit};
      rem_q <= q_bit ? rem_diff[23:0] : rem_sh[23:0];
    end
    if (state_q == gre_pkg::ST_SCAN && scan_take) begin
      best_diff_q <= scan_diff;
      best_q      <= best_nx;
    end
  end

  assign busy           = (state_q != gre_pkg::ST_IDLE);
  assign done_o         = done_q;
  assign gear_o         = gear_q;
  assign ratio_o        = ratio_q;
  assign smooth_rpm_o   = frpm_q;
  assign smooth_speed_o = fspd_q;
  assign status_o       = status_q;
  assign cfg_ready_o    = 1'b1;

endmodule

### sv/gre_checker.sv
// Port-level checks of the gear ratio estimator and their binding.
`include "gear_ratio_estimator_assert.svh"

module gre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [3:0]  gear_o,
  input logic [31:0] ratio_o
);

  `GRE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  `GRE_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `GRE_ASSERT(a_done_on_fall, $fell(busy) |-> done_o, "busy dropped without a result")
  `GRE_NEVER(a_gear_floor, done_o && gear_o != 4'd0 && ratio_o < 32'd9, "gear shown for tiny ratio")

endmodule

bind gear_ratio_estimator gre_checker u_gre_checker (.*);
